[hdl/assert_macros.svh]
// Assertion helpers for the message hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SHA_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("sha256: invariant violated");
`define SHA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sha256: implication violated");
`else
`define SHA_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define SHA_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/sha_pkg.sv]
package sha_pkg;

   typedef logic [31:0]        word_type;
   typedef word_type [7:0]     hash_type;   // element 0 is a, element 7 is h
   typedef logic [5:0]         round_type;

   localparam logic [2:0] MAX_BYTES = 3'd4;

   localparam hash_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type big_sigma0(word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

[hdl/sha_if.sv]
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [31:0] data_word;
   logic [2:0] byte_count;
   logic       last;

   modport source(output valid, data_word, byte_count, last, input ready);
   modport sink(input valid, data_word, byte_count, last, output ready);
endinterface

interface sha_rsp_if;
   logic       valid;
   logic       ready;
   logic [63:0] digest_high;
   logic [63:0] digest_upper_mid;
   logic [63:0] digest_lower_mid;
   logic [63:0] digest_low;

   modport source(output valid, digest_high, digest_upper_mid, digest_lower_mid,
                  digest_low, input ready);
   modport sink(input valid, digest_high, digest_upper_mid, digest_lower_mid,
                digest_low, output ready);
endinterface

[hdl/sha_round.sv]
// One SHA-256 compression round on the working variables.
module sha_round (
   input  sha_pkg::hash_type work,
   input  sha_pkg::word_type sched_word,
   input  sha_pkg::word_type round_const,
   output sha_pkg::hash_type work_next
);

   sha_pkg::word_type t1;
   sha_pkg::word_type t2;
   sha_pkg::word_type choose;
   sha_pkg::word_type majority;

   assign choose   = (work[4] & work[5]) ^ (~work[4] & work[6]);
   assign majority = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
   assign t1 = work[7] + sha_pkg::big_sigma1(work[4]) + choose + round_const + sched_word;
   assign t2 = sha_pkg::big_sigma0(work[0]) + majority;

   always_comb begin
      work_next[7] = work[6];
      work_next[6] = work[5];
      work_next[5] = work[4];
      work_next[4] = work[3] + t1;
      work_next[3] = work[2];
      work_next[2] = work[1];
      work_next[1] = work[0];
      work_next[0] = t1 + t2;
   end

endmodule

[hdl/sha256_message_hasher.sv]
// Channel   Dir  Handshake     Payload
// req_ch    in   valid/ready   data_word[31:0], byte_count[2:0], last
// rsp_ch    out  valid/ready   digest_high, digest_upper_mid, digest_lower_mid, digest_low
//
// Flow: ST_IDLE takes a word; ST_DATA passes an empty word on, pushes a word aligned with four
//   bytes whole, else walks it a byte at a time. Each full 64-byte block runs 64 rounds on the
//   shared unit, then one add. A last word adds the pad walk (0x80, zero bytes to a word edge,
//   zero words, a turn step, two length words), one or two compressions, and ST_OUTPUT to post the digest.
// Reset (synchronous) restores the initial hash and clears the byte count and the sequencer.
// A digest waits in its output register; only a second digest stalls, until it is taken.
`include "assert_macros.svh"

module sha256_message_hasher (
   input logic          clock,
   input logic          reset,
   sha_req_if.sink      req_ch,
   sha_rsp_if.source    rsp_ch
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_DATA     = 8'b0000_0010,
      ST_PAD_MARK = 8'b0000_0100,
      ST_PAD_ZERO = 8'b0000_1000,
      ST_PAD_LEN  = 8'b0001_0000,
      ST_ROUND    = 8'b0010_0000,
      ST_UPDATE   = 8'b0100_0000,
      ST_OUTPUT   = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   state_type          ret_ff, ret_in;       // where to resume after a compression
   state_type          after_state;
   sha_pkg::round_type round_ff, round_in;
   logic [5:0]         pos_ff, pos_in;       // byte position in the current block
   logic [63:0]        count_ff, count_in;   // message length in bytes
   logic [23:0]        acc_ff, acc_in;       // partial word built from single bytes
   logic [31:0]        word_ff, word_in;     // held input word, next byte at the top
   logic [2:0]         rem_ff, rem_in;       // bytes still to take from word_ff
   logic               last_ff, last_in;
   sha_pkg::word_type  sched_ff [16];
   sha_pkg::word_type  sched_in [16];
   sha_pkg::word_type  sched_next;
   sha_pkg::hash_type  work_ff, work_in, work_next;
   sha_pkg::hash_type  chain_ff, chain_in;
   sha_pkg::hash_type  digest_ff, digest_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               byte_en;
   logic [7:0]         byte_val;
   logic               word_en;
   sha_pkg::word_type  word_val;
   logic               push_en;
   sha_pkg::word_type  push_word;
   logic [63:0]        bit_length;

   assign bit_length = {count_ff[60:0], 3'b000};

   // Shared round unit: one round per cycle in ST_ROUND.
   sha_round u_round (
      .work        (work_ff),
      .sched_word  (sched_ff[0]),
      .round_const (sha_pkg::ROUND_K[round_ff]),
      .work_next   (work_next)
   );

   // Message expansion one word ahead: sched_ff[j] holds W[round + j].
   assign sched_next = sha_pkg::small_sigma1(sched_ff[14]) + sched_ff[9] +
                       sha_pkg::small_sigma0(sched_ff[1]) + sched_ff[0];

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      after_state  = state_ff;
      round_in     = round_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      word_in      = word_ff;
      rem_in       = rem_ff;
      last_in      = last_ff;
      work_in      = work_ff;
      chain_in     = chain_ff;
      digest_in    = digest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      byte_en      = 1'b0;
      byte_val     = 8'h00;
      word_en      = 1'b0;
      word_val     = '0;
      push_en      = 1'b0;
      push_word    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               word_in  = req_ch.data_word;
               rem_in   = (req_ch.byte_count > sha_pkg::MAX_BYTES) ?
                          sha_pkg::MAX_BYTES : req_ch.byte_count;
               last_in  = req_ch.last;
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (rem_ff == 3'd0) begin
               state_in = last_ff ? ST_PAD_MARK : ST_IDLE;
            end else begin
               // Whole word when aligned, else walk the bytes one a cycle, pausing while a full block compresses
               if (pos_ff[1:0] == 2'd0 && rem_ff == sha_pkg::MAX_BYTES) begin
                  word_en  = 1'b1;
                  word_val = word_ff;
                  rem_in   = 3'd0;
                  count_in = count_ff + 64'd4;
               end else begin
                  byte_en  = 1'b1;
                  byte_val = word_ff[31:24];
                  word_in  = {word_ff[23:0], 8'h00};
                  rem_in   = rem_ff - 3'd1;
                  count_in = count_ff + 64'd1;
               end
               if (rem_in == 3'd0) begin
                  after_state = last_ff ? ST_PAD_MARK : ST_IDLE;
               end else begin
                  after_state = ST_DATA;
               end
            end
         end
         ST_PAD_MARK: begin
            byte_en     = 1'b1;
            byte_val    = 8'h80;
            after_state = ST_PAD_ZERO;
         end
         ST_PAD_ZERO: begin
            // Past 56 the fill runs to the block end, wraps, and restarts at zero
            if (pos_ff == 6'd56) begin
               state_in = ST_PAD_LEN;
            end else if (pos_ff[1:0] == 2'd0) begin
               word_en     = 1'b1;
               after_state = ST_PAD_ZERO;
            end else begin
               byte_en     = 1'b1;
               after_state = ST_PAD_ZERO;
            end
         end
         ST_PAD_LEN: begin
            word_en     = 1'b1;
            word_val    = pos_ff[2] ? bit_length[31:0] : bit_length[63:32];
            after_state = pos_ff[2] ? ST_OUTPUT : ST_PAD_LEN;
         end
         ST_ROUND: begin
            work_in  = work_next;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            state_in = ret_ff;
         end
         ST_OUTPUT: begin
            // Hold here while the previous digest is still waiting
            if (!rsp_valid_ff || rsp_ch.ready) begin
               digest_in    = chain_ff;
               rsp_valid_in = 1'b1;
               chain_in     = sha_pkg::INIT_HASH;
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Shared byte and word step into the block
      if (byte_en) begin
         pos_in = pos_ff + 6'd1;
         acc_in = {acc_ff[15:0], byte_val};
         if (pos_ff[1:0] == 2'd3) begin
            push_en   = 1'b1;
            push_word = {acc_ff, byte_val};
         end
      end
      if (word_en) begin
         pos_in    = pos_ff + 6'd4;
         push_en   = 1'b1;
         push_word = word_val;
      end
      if (byte_en || word_en) begin
         if (push_en && pos_in == 6'd0) begin
            // Block full: load the working variables and run the rounds
            state_in = ST_ROUND;
            ret_in   = after_state;
            round_in = '0;
            work_in  = chain_ff;
         end else begin
            state_in = after_state;
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 16; j++) begin
         sched_in[j] = sched_ff[j];
      end
      if (push_en) begin
         for (int j = 0; j < 15; j++) begin
            sched_in[j] = sched_ff[j + 1];
         end
         sched_in[15] = push_word;
      end else if (state_ff == ST_ROUND) begin
         for (int j = 0; j < 15; j++) begin
            sched_in[j] = sched_ff[j + 1];
         end
         sched_in[15] = sched_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         round_ff     <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         chain_ff     <= sha_pkg::INIT_HASH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         round_ff     <= round_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      word_ff   <= word_in;
      rem_ff    <= rem_in;
      last_ff   <= last_in;
      work_ff   <= work_in;
      digest_ff <= digest_in;
      for (int j = 0; j < 16; j++) begin
         sched_ff[j] <= sched_in[j];
      end
   end

   assign req_ch.ready            = (state_ff == ST_IDLE);
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.digest_high      = {digest_ff[0], digest_ff[1]};
   assign rsp_ch.digest_upper_mid = {digest_ff[2], digest_ff[3]};
   assign rsp_ch.digest_lower_mid = {digest_ff[4], digest_ff[5]};
   assign rsp_ch.digest_low       = {digest_ff[6], digest_ff[7]};

   // Data bytes and the block position advance together
   `SHA_ASSERT_IMPLY(a_data_pos_sync, clock, reset, state_ff == ST_DATA, count_ff[5:0] == pos_ff)
   // Length words land only on the last two word slots of a block
   `SHA_ASSERT_IMPLY(a_len_aligned, clock, reset, state_ff == ST_PAD_LEN, (pos_ff | 6'd4) == 6'd60)
   // Compression only runs on a full block, starting at round zero
   `SHA_ASSERT_IMPLY(a_round_start, clock, reset, $rose(state_ff == ST_ROUND), ~|{round_ff, pos_ff})

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

   // Standard SHA-256 round constants and initial hash value, kept local so the
   // expected digests do not lean on the package under test.
   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };
   localparam logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Message lengths in bytes around the padding corners: the 0x80 byte and the
   // length field fitting in one final block or spilling into a second one.
   localparam int unsigned PAD_CORNER_LENGTHS [18] = '{
      0, 1, 3, 4, 5, 52, 55, 56, 57, 59, 60, 63, 64, 65, 119, 120, 127, 128
   };

   localparam int unsigned WORD_TARGET   = 1400;
   localparam int unsigned HOLD_AFTER    = 400;    // words accepted before the long hold
   localparam int unsigned HOLD_CYCLES   = 3000;
   localparam int unsigned DRAIN_CYCLES  = 300;    // two compressions plus padding
   localparam int unsigned CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  nbytes;
      logic        last;
   } msg_word_type;

   typedef struct packed {
      logic [63:0] high;
      logic [63:0] upper_mid;
      logic [63:0] lower_mid;
      logic [63:0] low;
   } digest_type;

   logic clock;
   logic reset;

   sha_req_if req_bus ();
   sha_rsp_if rsp_bus ();

   sha256_message_hasher dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #2 clock = ~clock;

   // Stimulus and scoreboard storage
   msg_word_type words_to_send[$];
   digest_type   expected_digests[$];
   int unsigned words_queued;
   int unsigned messages_queued;
   int unsigned words_accepted;
   int unsigned digests_checked;
   int unsigned mismatches;
   int unsigned cycle_count;
   int unsigned send_gap;
   int unsigned rsp_stall;
   int unsigned hold_left;
   logic        hold_done;

   // Mirror of the hasher's running state
   logic [31:0] chain_h [8];
   logic [7:0]  msg_block [64];
   logic [63:0] msg_len;

   function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Idle length for either side: mostly none or short, now and then long.
   // While cycle_count[11:9] is 5, hold a window with no idling at all.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (cycle_count[11:9] == 3'b101)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   function automatic int unsigned pick_msg_len();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return PAD_CORNER_LENGTHS[$urandom_range(0, 17)];
      else if (r < 9)
         return $urandom_range(0, 80);
      else
         return $urandom_range(81, 300);
   endfunction

   // Run one 64-round compression over msg_block and fold it into chain_h.
   task automatic compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      int i;
      for (i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
      e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
      for (i = 0; i < 64; i++) begin
         if (i >= 16) begin
            s0 = rotr(w[(i-15) & 15], 7) ^ rotr(w[(i-15) & 15], 18) ^ (w[(i-15) & 15] >> 3);
            s1 = rotr(w[(i-2) & 15], 17) ^ rotr(w[(i-2) & 15], 19) ^ (w[(i-2) & 15] >> 10);
            w[i & 15] = s1 + w[(i-7) & 15] + s0 + w[i & 15];
         end
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + SHA_K[i] + w[i & 15];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endtask

   // Absorb one accepted word; on the last word pad, finish and queue the digest.
   task automatic absorb_word(msg_word_type mw);
      int unsigned n, k, pos;
      logic [63:0] bit_len;
      digest_type dg;
      // Counts above four saturate; bytes past the count are ignored
      n = (mw.nbytes > 3'd4) ? 4 : mw.nbytes;
      for (k = 0; k < n; k++) begin
         pos = msg_len[5:0];
         msg_block[pos] = mw.data[31 - 8*k -: 8];
         msg_len++;
         if (pos == 63)
            compress_block();
      end
      if (mw.last) begin
         pos = msg_len[5:0];
         msg_block[pos] = 8'h80;
         pos++;
         // No room for the length field: close this block and pad a fresh one
         if (pos > 56) begin
            while (pos < 64) begin
               msg_block[pos] = 8'h00;
               pos++;
            end
            compress_block();
            pos = 0;
         end
         while (pos < 56) begin
            msg_block[pos] = 8'h00;
            pos++;
         end
         bit_len = msg_len << 3;
         for (k = 0; k < 8; k++)
            msg_block[56 + k] = bit_len[63 - 8*k -: 8];
         compress_block();
         dg.high      = {chain_h[0], chain_h[1]};
         dg.upper_mid = {chain_h[2], chain_h[3]};
         dg.lower_mid = {chain_h[4], chain_h[5]};
         dg.low       = {chain_h[6], chain_h[7]};
         expected_digests.push_back(dg);
         for (k = 0; k < 8; k++)
            chain_h[k] = SHA_IV[k];
         msg_len = '0;
      end
   endtask

   task automatic queue_word(logic [31:0] data, logic [2:0] nbytes, logic last);
      msg_word_type mw;
      mw.data   = data;
      mw.nbytes = nbytes;
      mw.last   = last;
      words_to_send.push_back(mw);
      // Empty words that are not last only get ignored; leave them out of the count
      if (nbytes != 3'd0 || last)
         words_queued++;
      if (last)
         messages_queued++;
   endtask

   // Queue a message of the given byte length as full words with random content,
   // sprinkled with noise: empty words, oversized counts and short middle words.
   task automatic queue_message(int unsigned len_bytes);
      int unsigned left, n;
      logic [2:0]  cnt;
      left = len_bytes;
      while (left > 4 || (left == 4 && $urandom_range(0, 1) == 1)) begin
         cnt = 3'd4;
         n   = 4;
         case ($urandom_range(0, 39))
            0: cnt = 3'($urandom_range(5, 7));
            1: queue_word($urandom, 3'd0, 1'b0);
            2: begin
               n   = $urandom_range(1, 3);
               cnt = 3'(n);
            end
            default: ;
         endcase
         queue_word($urandom, cnt, 1'b0);
         left -= n;
      end
      // Final word carries the rest; a full last word sometimes has an oversized count
      cnt = 3'(left);
      if (left == 4 && $urandom_range(0, 3) == 0)
         cnt = 3'($urandom_range(5, 7));
      queue_word($urandom, cnt, 1'b1);
   endtask

   // Cycle counter and watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d digests still owed",
                  cycle_count, expected_digests.size());
         $display("FAIL sha256_message_hasher");
         $finish;
      end
   end

   // Request driver: hold each word until the transaction completes, then idle
   // for the gap drawn when it was offered before presenting the next one.
   always @(posedge clock) begin : req_driver
      msg_word_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap != 0 || words_to_send.size() == 0) begin
            req_bus.valid <= 1'b0;
            if (send_gap != 0)
               send_gap <= send_gap - 1;
         end else begin
            nxt = words_to_send.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.data_word  <= nxt.data;
            req_bus.byte_count <= nxt.nbytes;
            req_bus.last       <= nxt.last;
            send_gap           <= pick_gap();
         end
      end
   end

   // Long hold-off: once enough words are in, block the digest port for a long
   // stretch so the output register fills and the input backs up.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && words_accepted >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // Digest receiver: drop ready for random stretches, and for the whole hold-off.
   always @(posedge clock) begin : rsp_pacer
      int unsigned g;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     <= 0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall != 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     <= rsp_stall - 1;
      end else begin
         g = pick_gap();
         rsp_bus.ready <= (g == 0);
         rsp_stall     <= (g == 0) ? 0 : g - 1;
      end
   end

   // Request monitor: every accepted word advances the expected hash state.
   always @(posedge clock) begin : req_monitor
      msg_word_type mw;
      if (!reset && req_bus.valid && req_bus.ready) begin
         mw.data   = req_bus.data_word;
         mw.nbytes = req_bus.byte_count;
         mw.last   = req_bus.last;
         absorb_word(mw);
         words_accepted <= words_accepted + 1;
      end
   end

   // Digest monitor: compare each transaction with the oldest expected digest.
   always @(posedge clock) begin : rsp_monitor
      digest_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_digests.size() == 0) begin
            $error("digest with none expected: %h %h %h %h", rsp_bus.digest_high,
                   rsp_bus.digest_upper_mid, rsp_bus.digest_lower_mid, rsp_bus.digest_low);
            mismatches++;
         end else begin
            want = expected_digests.pop_front();
            if (rsp_bus.digest_high !== want.high) begin
               $error("digest_high: expected %h, got %h", want.high, rsp_bus.digest_high);
               mismatches++;
            end
            if (rsp_bus.digest_upper_mid !== want.upper_mid) begin
               $error("digest_upper_mid: expected %h, got %h",
                      want.upper_mid, rsp_bus.digest_upper_mid);
               mismatches++;
            end
            if (rsp_bus.digest_lower_mid !== want.lower_mid) begin
               $error("digest_lower_mid: expected %h, got %h",
                      want.lower_mid, rsp_bus.digest_lower_mid);
               mismatches++;
            end
            if (rsp_bus.digest_low !== want.low) begin
               $error("digest_low: expected %h, got %h", want.low, rsp_bus.digest_low);
               mismatches++;
            end
            digests_checked++;
         end
      end
   end

   initial begin : stimulus
      int k;
      clock              = 1'b0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.data_word  = '0;
      req_bus.byte_count = '0;
      req_bus.last       = 1'b0;
      rsp_bus.ready      = 1'b0;
      words_queued       = 0;
      messages_queued    = 0;
      words_accepted     = 0;
      digests_checked    = 0;
      mismatches         = 0;
      cycle_count        = 0;
      hold_done          = 1'b0;
      msg_len            = '0;
      for (k = 0; k < 8; k++)
         chain_h[k] = SHA_IV[k];

      // Directed: empty message, "abc" with junk in the unused byte, a lone zero
      // byte, an oversized count on a single word, empty and oversized words
      // mid-message, all-zero and all-ones data, and a 0x80 data byte followed by
      // an empty last word.
      queue_word(32'hffffffff, 3'd0, 1'b1);
      queue_word(32'h616263a5, 3'd3, 1'b1);
      queue_word(32'h00000000, 3'd1, 1'b1);
      queue_word(32'hffffffff, 3'd7, 1'b1);
      queue_word(32'hdeadbeef, 3'd0, 1'b0);
      queue_word(32'h01234567, 3'd5, 1'b0);
      queue_word(32'h89abcdef, 3'd6, 1'b0);
      queue_word(32'h00000000, 3'd4, 1'b0);
      queue_word(32'hffffffff, 3'd2, 1'b1);
      queue_word(32'h80000000, 3'd4, 1'b0);
      queue_word(32'h00000000, 3'd0, 1'b1);
      queue_word(32'hffffffff, 3'd4, 1'b1);

      // Random messages of mixed length until the word budget is used up
      while (words_queued < WORD_TARGET)
         queue_message(pick_msg_len());

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last word to go in, then for every digest to come back
      while (words_to_send.size() != 0 || req_bus.valid)
         @(posedge clock);
      while (expected_digests.size() != 0)
         @(posedge clock);
      // Give a stray extra digest time to show up
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d messages in %0d words, %0d digests checked, %0d mismatches",
               messages_queued, words_accepted, digests_checked, mismatches);
      $display("covered padding corners, oversized and empty counts, and a %0d-cycle hold",
               HOLD_CYCLES);
      if (mismatches == 0)
         $display("PASS sha256_message_hasher");
      else
         $display("FAIL sha256_message_hasher");
      $finish;
   end

endmodule
